// ===== rtl/ucfc_pkg.sv =====
// shared types, codes and constants of the utf-8 character fold and classify core
package ucfc_pkg;

  // lead byte masks and patterns
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] ASCII_PAT  = 8'h00;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  // continuation counts set by a lead byte
  localparam logic [1:0] EXTRA_ONE   = 2'd1;
  localparam logic [1:0] EXTRA_TWO   = 2'd2;
  localparam logic [1:0] EXTRA_THREE = 2'd3;

  // character lengths
  localparam logic [2:0] LEN_ONE = 3'd1;

  // accent ranges, packed two-byte forms of the lowercase letters
  localparam logic [31:0] ACC_A_LO = 32'h0000_C3A0;
  localparam logic [31:0] ACC_A_HI = 32'h0000_C3A3;
  localparam logic [31:0] ACC_E_LO = 32'h0000_C3A8;
  localparam logic [31:0] ACC_E_HI = 32'h0000_C3AA;
  localparam logic [31:0] ACC_I_LO = 32'h0000_C3AC;
  localparam logic [31:0] ACC_I_HI = 32'h0000_C3AD;
  localparam logic [31:0] ACC_O_LO = 32'h0000_C3B2;
  localparam logic [31:0] ACC_O_HI = 32'h0000_C3B5;
  localparam logic [31:0] ACC_U_LO = 32'h0000_C3B9;
  localparam logic [31:0] ACC_U_HI = 32'h0000_C3BA;
  localparam logic [31:0] ACC_CEDIL = 32'h0000_C3A7;

  // offset between upper and lower case
  localparam logic [31:0] CASE_OFFSET = 32'h0000_0020;

  // ascii codes used by folding and classification
  localparam logic [31:0] CH_A_UP  = 32'd65;
  localparam logic [31:0] CH_Z_UP  = 32'd90;
  localparam logic [31:0] CH_A_LOW = 32'd97;
  localparam logic [31:0] CH_Z_LOW = 32'd122;
  localparam logic [31:0] CH_C_LOW = 32'd99;
  localparam logic [31:0] CH_E_LOW = 32'd101;
  localparam logic [31:0] CH_I_LOW = 32'd105;
  localparam logic [31:0] CH_O_LOW = 32'd111;
  localparam logic [31:0] CH_U_LOW = 32'd117;
  localparam logic [31:0] CH_ZERO  = 32'd48;
  localparam logic [31:0] CH_NINE  = 32'd57;
  localparam logic [31:0] CH_UNDER = 32'd95;

  // separators
  localparam logic [31:0] SEP_SPACE  = 32'h20;
  localparam logic [31:0] SEP_TAB    = 32'h09;
  localparam logic [31:0] SEP_LF     = 32'h0A;
  localparam logic [31:0] SEP_CR     = 32'h0D;
  localparam logic [31:0] SEP_DASH   = 32'h2D;
  localparam logic [31:0] SEP_DQUOTE = 32'h22;
  localparam logic [31:0] SEP_LBRACK = 32'h5B;
  localparam logic [31:0] SEP_RBRACK = 32'h5D;
  localparam logic [31:0] SEP_LPAREN = 32'h28;
  localparam logic [31:0] SEP_RPAREN = 32'h29;
  localparam logic [31:0] SEP_PERIOD = 32'h2E;
  localparam logic [31:0] SEP_COMMA  = 32'h2C;
  localparam logic [31:0] SEP_COLON  = 32'h3A;
  localparam logic [31:0] SEP_SEMI   = 32'h3B;
  localparam logic [31:0] SEP_QUEST  = 32'h3F;
  localparam logic [31:0] SEP_EXCL   = 32'h21;
  localparam logic [31:0] SEP_LDQUO  = 32'hE2_809C;
  localparam logic [31:0] SEP_RDQUO  = 32'hE2_809D;
  localparam logic [31:0] SEP_ENDASH = 32'hE2_8093;
  localparam logic [31:0] SEP_ELLIP  = 32'hE2_80A6;

  // completed character between assembler and classifier
  typedef struct packed {
    logic [31:0] raw_char;
    logic [2:0]  char_len;
    logic        bad_lead;
  } char_stage_t;

  // classification of a completed character
  typedef struct packed {
    logic [31:0] folded_char;
    logic        is_separator;
    logic        is_word_char;
  } char_class_t;

endpackage

// ===== rtl/ucfc_if.sv =====
// valid/ready channel interfaces for input bytes and result characters
interface ucfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface ucfc_char_if;
  logic        valid;
  logic        ready;
  logic [31:0] raw_char;
  logic [31:0] folded_char;
  logic [2:0]  char_len;
  logic        is_separator;
  logic        is_word_char;
  logic        bad_lead;

  modport source (output valid, output raw_char, output folded_char, output char_len,
                  output is_separator, output is_word_char, output bad_lead, input ready);
  modport sink (input valid, input raw_char, input folded_char, input char_len,
                input is_separator, input is_word_char, input bad_lead, output ready);
endinterface

// ===== rtl/ucfc_assemble.sv =====
// byte assembler: lead decode, continuation shift and the completed-character register
module ucfc_assemble (
  input  logic                  clk,
  input  logic                  rst,
  ucfc_byte_if.sink             in_ch,
  input  logic                  adv,
  output ucfc_pkg::char_stage_t stage,
  output logic                  stage_valid
);
  import ucfc_pkg::*;

  logic [31:0] char_accum, char_accum_next;
  logic [1:0]  bytes_left, bytes_left_next;
  logic [2:0]  char_count, char_count_next;
  logic        take;
  logic        emit;
  char_stage_t emit_char;
  logic [31:0] shifted;
  logic [2:0]  count_inc;
  logic [1:0]  left_dec;

  // the stage register frees up when its item moves on
  assign in_ch.ready = !stage_valid || adv;
  assign take        = in_ch.valid && in_ch.ready;

  assign shifted   = {char_accum[23:0], in_ch.in_byte};
  assign count_inc = char_count + 3'd1;
  assign left_dec  = bytes_left - 2'd1;

  // next state and completed character for the byte on the input
  always_comb begin
    char_accum_next = char_accum;
    bytes_left_next = bytes_left;
    char_count_next = char_count;
    emit            = 1'b0;
    emit_char       = '{raw_char: {24'd0, in_ch.in_byte}, char_len: LEN_ONE, bad_lead: 1'b0};
    if (bytes_left != 2'd0) begin
      // continuation, shifted in unchecked
      bytes_left_next = left_dec;
      if (left_dec == 2'd0) begin
        emit            = 1'b1;
        emit_char       = '{raw_char: shifted, char_len: count_inc, bad_lead: 1'b0};
        char_accum_next = '0;
        char_count_next = '0;
      end else begin
        char_accum_next = shifted;
        char_count_next = count_inc;
      end
    end else if ((in_ch.in_byte & ASCII_MASK) == ASCII_PAT) begin
      emit = 1'b1;
    end else if ((in_ch.in_byte & LEAD2_MASK) == LEAD2_PAT) begin
      char_accum_next = {24'd0, in_ch.in_byte};
      bytes_left_next = EXTRA_ONE;
      char_count_next = LEN_ONE;
    end else if ((in_ch.in_byte & LEAD3_MASK) == LEAD3_PAT) begin
      char_accum_next = {24'd0, in_ch.in_byte};
      bytes_left_next = EXTRA_TWO;
      char_count_next = LEN_ONE;
    end else if ((in_ch.in_byte & LEAD4_MASK) == LEAD4_PAT) begin
      char_accum_next = {24'd0, in_ch.in_byte};
      bytes_left_next = EXTRA_THREE;
      char_count_next = LEN_ONE;
    end else begin
      // stray continuation or invalid lead goes out alone
      emit               = 1'b1;
      emit_char.bad_lead = 1'b1;
    end
  end

  // assembly state
  always_ff @(posedge clk) begin
    if (rst) begin
      char_accum <= '0;
      bytes_left <= '0;
      char_count <= '0;
    end else if (take) begin
      char_accum <= char_accum_next;
      bytes_left <= bytes_left_next;
      char_count <= char_count_next;
    end
  end

  // completed-character stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= emit;
    end else if (adv) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      stage <= emit_char;
    end
  end

  // no count left over between characters
  assert property (@(posedge clk) disable iff (rst)
    (bytes_left == 2'd0) |-> (char_count == 3'd0))
    else $error("byte count set with no continuation pending");

  // a character never spans more than four bytes
  assert property (@(posedge clk) disable iff (rst)
    ({2'b00, bytes_left} + {1'b0, char_count}) <= 4'd4)
    else $error("character longer than four bytes");

  // a bad lead byte always leaves as a single byte
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && stage.bad_lead) |-> (stage.char_len == LEN_ONE &&
                                         stage.raw_char[31:8] == 24'd0))
    else $error("bad lead item longer than one byte");

  // a held stage item keeps its value until it moves on
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !adv) |=> (stage_valid && $stable(stage)))
    else $error("stage item changed while stalled");
endmodule

// ===== rtl/ucfc_classify.sv =====
// accent folding, lowercasing and separator / word-character classification
module ucfc_classify (
  input  ucfc_pkg::char_stage_t stage,
  output ucfc_pkg::char_class_t cls
);
  import ucfc_pkg::*;

  logic [31:0] raw;
  logic [31:0] raw_up;
  logic [31:0] acc_raw, acc_up;
  logic        hit_raw, hit_up;
  logic [31:0] unaccented;
  logic [31:0] folded;
  logic        sep, word;

  // accent lookup on one packed value
  function automatic logic [32:0] accent_fold(input logic [31:0] c);
    logic [32:0] r;
    r = {1'b0, c};
    if (c >= ACC_A_LO && c <= ACC_A_HI) begin
      r = {1'b1, CH_A_LOW};
    end else if (c >= ACC_E_LO && c <= ACC_E_HI) begin
      r = {1'b1, CH_E_LOW};
    end else if (c >= ACC_I_LO && c <= ACC_I_HI) begin
      r = {1'b1, CH_I_LOW};
    end else if (c >= ACC_O_LO && c <= ACC_O_HI) begin
      r = {1'b1, CH_O_LOW};
    end else if (c >= ACC_U_LO && c <= ACC_U_HI) begin
      r = {1'b1, CH_U_LOW};
    end else if (c == ACC_CEDIL) begin
      r = {1'b1, CH_C_LOW};
    end
    return r;
  endfunction

  assign raw    = stage.raw_char;
  assign raw_up = raw + CASE_OFFSET;

  // lowercase accented form first, then the uppercase one
  assign {hit_raw, acc_raw} = accent_fold(raw);
  assign {hit_up, acc_up}   = accent_fold(raw_up);

  always_comb begin
    if (hit_raw) begin
      unaccented = acc_raw;
    end else if (hit_up) begin
      unaccented = acc_up;
    end else begin
      unaccented = raw;
    end
  end

  // ascii lowercasing
  assign folded = (unaccented >= CH_A_UP && unaccented <= CH_Z_UP) ?
                  unaccented + CASE_OFFSET : unaccented;

  // separator set
  always_comb begin
    sep = folded inside {SEP_SPACE, SEP_TAB, SEP_LF, SEP_CR, SEP_DASH, SEP_DQUOTE,
                         SEP_LBRACK, SEP_RBRACK, SEP_LPAREN, SEP_RPAREN, SEP_PERIOD,
                         SEP_COMMA, SEP_COLON, SEP_SEMI, SEP_QUEST, SEP_EXCL,
                         SEP_LDQUO, SEP_RDQUO, SEP_ENDASH, SEP_ELLIP};
  end

  // word characters
  assign word = (folded >= CH_A_LOW && folded <= CH_Z_LOW) ||
                (folded >= CH_ZERO && folded <= CH_NINE) ||
                (folded == CH_UNDER);

  // flags are cleared for a bad lead
  assign cls.folded_char  = folded;
  assign cls.is_separator = sep && !stage.bad_lead;
  assign cls.is_word_char = word && !stage.bad_lead;
endmodule

// ===== rtl/utf8_char_fold_classify_core.sv =====
// top level of the utf-8 character fold and classify core
//
//  channel   dir   handshake     payload
//  in_ch     in    valid/ready   in_byte[7:0]
//  out_ch    out   valid/ready   raw_char, folded_char, char_len, is_separator,
//                                is_word_char, bad_lead
//
// one byte is taken every cycle while the output side keeps up; a character
// passes from its last byte into the assembler stage register, then through
// the fold/classify logic into the output register.
// bytes that do not finish a character produce no item.
// rst is synchronous and clears assembly state and both valid flags.
// a stalled output holds its item; the stage behind it keeps one more, and
// in_ch.ready falls only when both are full.
module utf8_char_fold_classify_core (
  input  logic        clk,
  input  logic        rst,
  ucfc_byte_if.sink   in_ch,
  ucfc_char_if.source out_ch
);
  import ucfc_pkg::*;

  char_stage_t stage;
  char_class_t cls;
  logic        stage_valid;
  logic        adv;

  // output register takes a new item when empty or being drained
  assign adv = !out_ch.valid || out_ch.ready;

  ucfc_assemble u_assemble (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .adv         (adv),
    .stage       (stage),
    .stage_valid (stage_valid)
  );

  ucfc_classify u_classify (
    .stage (stage),
    .cls   (cls)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= stage_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv && stage_valid) begin
      out_ch.raw_char     <= stage.raw_char;
      out_ch.folded_char  <= cls.folded_char;
      out_ch.char_len     <= stage.char_len;
      out_ch.is_separator <= cls.is_separator;
      out_ch.is_word_char <= cls.is_word_char;
      out_ch.bad_lead     <= stage.bad_lead;
    end
  end
endmodule

// ===== verif/tb.sv =====
// self-checking testbench of the utf-8 character fold and classify core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_BYTES   = 480;

  // one completed character as seen on the output channel
  typedef struct packed {
    logic [31:0] raw_char;
    logic [31:0] folded_char;
    logic [2:0]  char_len;
    logic        is_separator;
    logic        is_word_char;
    logic        bad_lead;
  } char_result_t;

  logic clk;
  logic rst;

  ucfc_byte_if in_ch();
  ucfc_char_if out_ch();

  utf8_char_fold_classify_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  char_result_t expected_chars[$];
  logic [31:0]  asm_bytes = '0;
  logic [1:0]   asm_left  = '0;
  logic [2:0]   asm_count = '0;
  int           errors = 0;
  int           bytes_sent = 0;
  int           quiet_cycles = 0;
  int           hold_request = 0;
  bit           send_gaps_on = 1'b1;
  bit           ready_gaps_on = 1'b1;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // plain letter of a lowercase accented vowel or c-cedilla, zero on a miss
  function automatic logic [31:0] accent_base(input logic [31:0] c);
    if (c >= 32'hC3A0 && c <= 32'hC3A3) return 32'd97;   // a
    if (c >= 32'hC3A8 && c <= 32'hC3AA) return 32'd101;  // e
    if (c >= 32'hC3AC && c <= 32'hC3AD) return 32'd105;  // i
    if (c >= 32'hC3B2 && c <= 32'hC3B5) return 32'd111;  // o
    if (c >= 32'hC3B9 && c <= 32'hC3BA) return 32'd117;  // u
    if (c == 32'hC3A7) return 32'd99;                     // c
    return 32'd0;
  endfunction

  // accent removal first, uppercase accents through the case offset, then a-z
  function automatic logic [31:0] fold_char(input logic [31:0] c);
    logic [31:0] r;
    r = accent_base(c);
    if (r == 32'd0) r = accent_base(c + 32'h20);
    if (r == 32'd0) r = c;
    if (r >= 32'd65 && r <= 32'd90) r = r + 32'd32;
    return r;
  endfunction

  function automatic logic separates(input logic [31:0] c);
    case (c)
      32'h20, 32'h09, 32'h0A, 32'h0D, 32'h2D, 32'h22, 32'h5B, 32'h5D,
      32'h28, 32'h29, 32'h2E, 32'h2C, 32'h3A, 32'h3B, 32'h3F, 32'h21,
      32'hE2809C, 32'hE2809D, 32'hE28093, 32'hE280A6: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic word_letter(input logic [31:0] c);
    return (c >= 32'd97 && c <= 32'd122) || (c >= 32'd48 && c <= 32'd57) || c == 32'd95;
  endfunction

  task automatic post_char(input logic [31:0] raw, input logic [2:0] len, input logic bad);
    char_result_t r;
    r.raw_char     = raw;
    r.folded_char  = fold_char(raw);
    r.char_len     = len;
    r.is_separator = bad ? 1'b0 : separates(r.folded_char);
    r.is_word_char = bad ? 1'b0 : word_letter(r.folded_char);
    r.bad_lead     = bad;
    expected_chars.push_back(r);
  endtask

  // character assembly of one accepted byte
  task automatic assemble_byte(input logic [7:0] b);
    logic [1:0] extra;
    extra = 2'd0;
    if (asm_left != 2'd0) begin
      // continuation, shifted in unchecked
      asm_bytes = {asm_bytes[23:0], b};
      asm_count = asm_count + 3'd1;
      asm_left  = asm_left - 2'd1;
      if (asm_left == 2'd0) begin
        post_char(asm_bytes, asm_count, 1'b0);
        asm_bytes = '0;
        asm_count = '0;
      end
    end else begin
      casez (b)
        8'b0???????: post_char({24'd0, b}, 3'd1, 1'b0);
        8'b110?????: extra = 2'd1;
        8'b1110????: extra = 2'd2;
        8'b11110???: extra = 2'd3;
        default:     post_char({24'd0, b}, 3'd1, 1'b1);
      endcase
      if (extra != 2'd0) begin
        asm_bytes = {24'd0, b};
        asm_left  = extra;
        asm_count = 3'd1;
      end
    end
  endtask

  // input monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) assemble_byte(in_ch.in_byte);
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    end
  endtask

  // output monitor compares against the oldest expected character
  always @(posedge clk) begin : result_check
    char_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none actual raw_char %h", $time,
                 out_ch.raw_char);
      end else begin
        want = expected_chars.pop_front();
        check_field("raw_char", want.raw_char, out_ch.raw_char);
        check_field("folded_char", want.folded_char, out_ch.folded_char);
        check_field("char_len", 32'(want.char_len), 32'(out_ch.char_len));
        check_field("is_separator", 32'(want.is_separator), 32'(out_ch.is_separator));
        check_field("is_word_char", 32'(want.is_word_char), 32'(out_ch.is_word_char));
        check_field("bad_lead", 32'(want.bad_lead), 32'(out_ch.bad_lead));
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // idle length: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver: random stalls plus the long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (ready_gaps_on && $urandom_range(0, 99) < 25) begin
        out_ch.ready <= 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // send one byte, waiting for it to be accepted; valid stays high on return
  task automatic feed_byte(input logic [7:0] b);
    int gap;
    gap = (send_gaps_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // continuation byte, mostly of the 10xxxxxx form
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h80, 8'hBF));
    return 8'($urandom);
  endfunction

  // one character of random text, mostly well formed
  task automatic feed_random_char();
    int pick;
    logic [7:0] tail;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      feed_byte(8'($urandom_range(0, 127)));
    end else if (pick < 62) begin
      // two-byte, half of them in the accented latin block
      feed_byte($urandom_range(0, 1) ? 8'hC3 : 8'($urandom_range(8'hC0, 8'hDF)));
      feed_byte(cont_byte());
    end else if (pick < 76) begin
      if ($urandom_range(0, 1)) begin
        // typographic quotes, dash and ellipsis
        case ($urandom_range(0, 3))
          0: tail = 8'h9C;
          1: tail = 8'h9D;
          2: tail = 8'h93;
          default: tail = 8'hA6;
        endcase
        feed_byte(8'hE2);
        feed_byte(8'h80);
        feed_byte(tail);
      end else begin
        feed_byte(8'($urandom_range(8'hE0, 8'hEF)));
        repeat (2) feed_byte(cont_byte());
      end
    end else if (pick < 86) begin
      feed_byte(8'($urandom_range(8'hF0, 8'hF7)));
      repeat (3) feed_byte(cont_byte());
    end else if (pick < 94) begin
      // bad lead: stray continuation or 11111xxx
      feed_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                     : 8'($urandom_range(8'hF8, 8'hFF)));
    end else begin
      feed_byte(8'($urandom));
    end
  endtask

  task automatic test_ascii_extremes();
    feed_byte(8'h00);
    feed_byte(8'h7F);
    feed_byte(8'h41);
    feed_byte(8'h5A);
    feed_byte(8'h5F);
    feed_byte(8'h09);
  endtask

  // lowercase and uppercase accents fold to plain letters
  task automatic test_accent_fold();
    feed_byte(8'hC3);
    feed_byte(8'hA7);
    feed_byte(8'hC3);
    feed_byte(8'h87);
    feed_byte(8'hC3);
    feed_byte(8'h80);
  endtask

  task automatic test_three_byte_separator();
    feed_byte(8'hE2);
    feed_byte(8'h80);
    feed_byte(8'h9C);
  endtask

  task automatic test_four_byte();
    feed_byte(8'hF0);
    feed_byte(8'h9F);
    feed_byte(8'h98);
    feed_byte(8'h80);
  endtask

  task automatic test_bad_lead();
    feed_byte(8'h80);
    feed_byte(8'hFF);
    feed_byte(8'hF8);
  endtask

  // a lead byte where a continuation is due is taken as a continuation
  task automatic test_lead_in_continuation();
    feed_byte(8'hC3);
    feed_byte(8'hC3);
  endtask

  task automatic test_random_text();
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 3) send_gaps_on = !send_gaps_on;
      if ($urandom_range(0, 99) < 3) ready_gaps_on = !ready_gaps_on;
      feed_random_char();
    end
    send_gaps_on = 1'b1;
    ready_gaps_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_output_backpressure();
    send_gaps_on = 1'b0;
    hold_request = LONG_HOLD;
    repeat (40) feed_byte(8'($urandom_range(0, 127)));
    send_gaps_on = 1'b1;
  endtask

  // full rate on both sides
  task automatic test_back_to_back();
    send_gaps_on = 1'b0;
    ready_gaps_on = 1'b0;
    repeat (10) feed_random_char();
    send_gaps_on = 1'b1;
    ready_gaps_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_ascii_extremes();
    test_accent_fold();
    test_three_byte_separator();
    test_four_byte();
    test_bad_lead();
    test_lead_in_continuation();
    test_random_text();
    test_output_backpressure();
    test_back_to_back();

    // close any open character
    repeat (3) feed_byte(8'h61);
    in_ch.valid <= 1'b0;

    @(posedge clk);
    wait (expected_chars.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
